// ===== src/tccw_pkg.sv =====
// text console cell writer: shared geometry, character codes and microcode
// types, plus the control store read by the sequencer
// depends on nothing
`timescale 1ns / 1ps

package tccw_pkg;

	// screen geometry
	localparam int COLS   = 80;
	localparam int ROWS   = 25;
	localparam int CELLS  = ROWS * COLS;
	localparam int ADDR_W = $clog2(CELLS);

	// field widths
	localparam int COL_W   = 7;
	localparam int ROW_W   = 5;
	localparam int POS_W   = 11;
	localparam int IDX_W   = 11;
	localparam int CELL_W  = 16;
	localparam int CHAR_W  = 8;
	localparam int FUNC_W  = 2;
	localparam int COLOR_W = 4;
	localparam int TAB_STOP = 8;

	// stream packing
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 32;

	// control characters
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

	// operation codes
	typedef enum logic [FUNC_W-1:0] {
		FN_PUT   = 2'd0,
		FN_CLEAR = 2'd1,
		FN_READ  = 2'd2
	} func_t;

	// configuration register indexes
	typedef enum logic {
		REG_FG = 1'b0,
		REG_BG = 1'b1
	} reg_idx_t;

	// microprogram addresses
	localparam int STEP_W = 3;
	typedef logic [STEP_W-1:0] step_t;
	localparam step_t ST_FETCH     = 3'd0;
	localparam step_t ST_PUT       = 3'd1;
	localparam step_t ST_SCR_START = 3'd2;
	localparam step_t ST_SCR_COPY  = 3'd3;
	localparam step_t ST_BLANK     = 3'd4;
	localparam step_t ST_CLEAR     = 3'd5;
	localparam step_t ST_READ      = 3'd6;
	localparam step_t ST_NOP       = 3'd7;

	// datapath action of one step
	typedef enum logic [2:0] {
		OP_FETCH,
		OP_PUT,
		OP_SCR_START,
		OP_COPY,
		OP_BLANK,
		OP_CLEAR,
		OP_READ,
		OP_IDLE
	} op_t;

	// branch condition
	typedef enum logic [2:0] {
		C_DISPATCH,
		C_ALWAYS,
		C_SCROLL,
		C_COPY_LAST,
		C_BLANK_LAST
	} cond_t;

	// when a step hands a result to the output register
	typedef enum logic [1:0] {
		EM_NONE,
		EM_TAKEN,
		EM_NOT_TAKEN,
		EM_ALWAYS
	} emit_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		emit_t emit;
		step_t next_t;
		step_t next_f;
	} ucw_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic  accept;
		func_t func;
		logic  scroll;
		logic  copy_last;
		logic  blank_last;
		logic  out_busy;
	} seq_status_t;

	// control store
	function automatic ucw_t ucode(input step_t s);
		ucw_t w;
		case (s)
			ST_FETCH:     w = '{OP_FETCH,     C_DISPATCH,   EM_NONE,      ST_FETCH,    ST_FETCH};
			ST_PUT:       w = '{OP_PUT,       C_SCROLL,     EM_NOT_TAKEN, ST_SCR_START, ST_FETCH};
			ST_SCR_START: w = '{OP_SCR_START, C_ALWAYS,     EM_NONE,      ST_SCR_COPY, ST_SCR_COPY};
			ST_SCR_COPY:  w = '{OP_COPY,      C_COPY_LAST,  EM_NONE,      ST_BLANK,    ST_SCR_COPY};
			ST_BLANK:     w = '{OP_BLANK,     C_BLANK_LAST, EM_TAKEN,     ST_FETCH,    ST_BLANK};
			ST_CLEAR:     w = '{OP_CLEAR,     C_ALWAYS,     EM_NONE,      ST_BLANK,    ST_BLANK};
			ST_READ:      w = '{OP_READ,      C_ALWAYS,     EM_ALWAYS,    ST_FETCH,    ST_FETCH};
			ST_NOP:       w = '{OP_IDLE,      C_ALWAYS,     EM_ALWAYS,    ST_FETCH,    ST_FETCH};
			default:      w = '{OP_FETCH,     C_DISPATCH,   EM_NONE,      ST_FETCH,    ST_FETCH};
		endcase
		return w;
	endfunction

	// linear cursor position, kept to the output width
	function automatic logic [POS_W-1:0] pos_of(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		return POS_W'(int'(r) * COLS + int'(c));
	endfunction

endpackage

// ===== src/text_console_cell_writer_top.sv =====
// text console cell writer top level: stream ports, cursor and copy datapath
// depends on tccw_pkg, tccw_screen_ram, tccw_sequencer
`timescale 1ns / 1ps

// Text console of 25 rows by 80 columns of 16-bit cells (character in the low
// byte, foreground nibble then background nibble above) with a cursor. Each
// request on the input stream gives exactly one result on the output stream.
// Clear and a put that scrolls sweep the screen store cell by cell: every
// cell move or blank goes through the single write port of the screen store
// at one cell per cycle. A full output register that is not drained holds the
// step that delivers a result. Cells read before they were ever written give
// undefined data; an index past the last cell reads as zero. The color
// registers are written through the cfg port, which is always ready.

module text_console_cell_writer_top (
	input  logic                           clk,
	input  logic                           arst_n,
	// input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [tccw_pkg::IN_DATA_W-1:0] s_tdata,  // func, char_code, cell_index, pad
	// output stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [tccw_pkg::OUT_DATA_W-1:0] m_tdata, // cursor_pos, read_cell, did_scroll, pad
	// configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_index,
	input  logic [tccw_pkg::COLOR_W-1:0]   cfg_data
);

	localparam int ROW_X_W = tccw_pkg::ROW_W + 1;
	localparam int COL_X_W = tccw_pkg::COL_W + 1;

	tccw_pkg::ucw_t        cw;
	tccw_pkg::seq_status_t st;
	logic                  go;
	logic                  emit;
	logic                  accept;

	// input fields
	logic [tccw_pkg::CHAR_W-1:0] in_char;
	logic [tccw_pkg::IDX_W-1:0]  in_idx;

	// state
	logic [tccw_pkg::COL_W-1:0]   col_q;
	logic [tccw_pkg::ROW_W-1:0]   row_q;
	logic [tccw_pkg::COLOR_W-1:0] fg_q;
	logic [tccw_pkg::COLOR_W-1:0] bg_q;
	logic [tccw_pkg::ADDR_W-1:0]  cnt_q;
	logic [tccw_pkg::CHAR_W-1:0]  char_q;
	logic [tccw_pkg::IDX_W-1:0]   idx_q;
	logic                         idx_ok_q;
	logic                         scroll_q;

	// output register
	logic                          out_valid_q;
	logic [tccw_pkg::POS_W-1:0]    out_pos_q;
	logic [tccw_pkg::CELL_W-1:0]   out_cell_q;
	logic                          out_scroll_q;

	// cursor datapath
	logic [COL_X_W-1:0]           col_n;
	logic [ROW_X_W-1:0]           row_n;
	logic [ROW_X_W-1:0]           row_w;
	logic [tccw_pkg::COL_W-1:0]   col_f;
	logic [tccw_pkg::ROW_W-1:0]   row_f;
	logic                         printable;
	logic                         scroll_n;

	// memory ports
	logic                         ram_we;
	logic [tccw_pkg::ADDR_W-1:0]  ram_waddr;
	logic [tccw_pkg::CELL_W-1:0]  ram_wdata;
	logic [tccw_pkg::ADDR_W-1:0]  ram_raddr;
	logic [tccw_pkg::CELL_W-1:0]  ram_rdata;
	logic [tccw_pkg::CELL_W-1:0]  blank;
	logic [tccw_pkg::CELL_W-1:0]  put_cell;

	assign in_char = s_tdata[9:2];
	assign in_idx  = s_tdata[20:10];

	assign s_tready  = (cw.op == tccw_pkg::OP_FETCH);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign blank    = {bg_q, fg_q, tccw_pkg::CH_SPACE};
	assign put_cell = {bg_q, fg_q, char_q};

	// sequencer status
	always_comb begin
		st.accept     = accept;
		st.func       = tccw_pkg::func_t'(s_tdata[1:0]);
		st.scroll     = scroll_n;
		st.copy_last  = (cnt_q == tccw_pkg::ADDR_W'(tccw_pkg::CELLS - tccw_pkg::COLS - 1));
		st.blank_last = (cnt_q == tccw_pkg::ADDR_W'(tccw_pkg::CELLS - 1));
		st.out_busy   = out_valid_q && !m_tready;
	end

	tccw_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cw     (cw),
		.go     (go),
		.emit   (emit)
	);

	// cursor move for one put
	always_comb begin
		printable = 1'b0;
		row_n     = {1'b0, row_q};
		case (char_q)
			tccw_pkg::CH_BACKSPACE: begin
				col_n = (col_q == '0) ? '0 : {1'b0, col_q} - COL_X_W'(1);
			end
			tccw_pkg::CH_TAB: begin
				col_n = ({1'b0, col_q} + COL_X_W'(tccw_pkg::TAB_STOP))
					& ~COL_X_W'(tccw_pkg::TAB_STOP - 1);
			end
			tccw_pkg::CH_RETURN: begin
				col_n = '0;
			end
			tccw_pkg::CH_NEWLINE: begin
				col_n = '0;
				row_n = {1'b0, row_q} + ROW_X_W'(1);
			end
			default: begin
				printable = 1'b1;
				col_n     = {1'b0, col_q} + COL_X_W'(1);
			end
		endcase
		// wrap to the next row, then scroll off the bottom
		if (col_n >= COL_X_W'(tccw_pkg::COLS)) begin
			col_f = '0;
			row_w = row_n + ROW_X_W'(1);
		end else begin
			col_f = col_n[tccw_pkg::COL_W-1:0];
			row_w = row_n;
		end
		scroll_n = (row_w >= ROW_X_W'(tccw_pkg::ROWS));
		row_f    = scroll_n ? tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1)
			: row_w[tccw_pkg::ROW_W-1:0];
	end

	// screen store port selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = blank;
		ram_raddr = cnt_q + tccw_pkg::ADDR_W'(tccw_pkg::COLS + 1);
		case (cw.op)
			tccw_pkg::OP_FETCH: begin
				ram_raddr = tccw_pkg::ADDR_W'(in_idx);
			end
			tccw_pkg::OP_PUT: begin
				ram_we    = go && printable;
				ram_waddr = tccw_pkg::ADDR_W'(tccw_pkg::pos_of(row_q, col_q));
				ram_wdata = put_cell;
			end
			tccw_pkg::OP_SCR_START: begin
				ram_raddr = tccw_pkg::ADDR_W'(tccw_pkg::COLS);
			end
			tccw_pkg::OP_COPY: begin
				ram_we    = go;
				ram_wdata = ram_rdata;
			end
			tccw_pkg::OP_BLANK: begin
				ram_we = go;
			end
			tccw_pkg::OP_READ: begin
				// keep the read data steady while the result waits
				ram_raddr = tccw_pkg::ADDR_W'(idx_q);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	tccw_screen_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// cursor, sweep counter and colors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			cnt_q    <= '0;
			scroll_q <= 1'b0;
			fg_q     <= tccw_pkg::COLOR_W'(15);
			bg_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (tccw_pkg::reg_idx_t'(cfg_index))
					tccw_pkg::REG_FG: fg_q <= cfg_data;
					tccw_pkg::REG_BG: bg_q <= cfg_data;
					default:          fg_q <= fg_q;
				endcase
			end
			if (go) begin
				case (cw.op)
					tccw_pkg::OP_PUT: begin
						col_q    <= col_f;
						row_q    <= row_f;
						scroll_q <= scroll_n;
					end
					tccw_pkg::OP_SCR_START: begin
						cnt_q <= '0;
					end
					tccw_pkg::OP_COPY, tccw_pkg::OP_BLANK: begin
						cnt_q <= cnt_q + tccw_pkg::ADDR_W'(1);
					end
					tccw_pkg::OP_CLEAR: begin
						col_q    <= '0;
						row_q    <= '0;
						cnt_q    <= '0;
						scroll_q <= 1'b0;
					end
					default: begin
						cnt_q <= cnt_q;
					end
				endcase
			end
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			char_q   <= in_char;
			idx_q    <= in_idx;
			idx_ok_q <= (in_idx < tccw_pkg::IDX_W'(tccw_pkg::CELLS));
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			if (cw.op == tccw_pkg::OP_PUT) begin
				out_pos_q <= tccw_pkg::pos_of(row_f, col_f);
			end else begin
				out_pos_q <= tccw_pkg::pos_of(row_q, col_q);
			end
			out_cell_q   <= (cw.op == tccw_pkg::OP_READ && idx_ok_q) ? ram_rdata : '0;
			out_scroll_q <= (cw.op == tccw_pkg::OP_BLANK) && scroll_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_scroll_q, out_cell_q, out_pos_q};

`ifndef NO_ASSERTIONS
	// cursor stays on the screen
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q < tccw_pkg::ROW_W'(tccw_pkg::ROWS))
		else $error("cursor row off screen");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q < tccw_pkg::COL_W'(tccw_pkg::COLS))
		else $error("cursor column off screen");

	// a scroll always leaves the cursor on the bottom row
	a_scroll_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && cw.op == tccw_pkg::OP_BLANK && scroll_q)
		|-> (row_q == tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1)))
		else $error("scroll result with cursor above bottom row");

	// one request at a time: no new request right after one is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("request taken while previous one in flight");
`endif

endmodule

// ===== src/tccw_screen_ram.sv =====
// screen cell store: one write port, one read port with registered data
// depends on tccw_pkg
`timescale 1ns / 1ps

module tccw_screen_ram (
	input  logic                        clk,
	input  logic                        we,
	input  logic [tccw_pkg::ADDR_W-1:0] waddr,
	input  logic [tccw_pkg::CELL_W-1:0] wdata,
	input  logic [tccw_pkg::ADDR_W-1:0] raddr,
	output logic [tccw_pkg::CELL_W-1:0] rdata
);

	logic [tccw_pkg::CELL_W-1:0] mem [tccw_pkg::CELLS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== src/tccw_sequencer.sv =====
// microcode sequencer: step counter, control store lookup and branching
// depends on tccw_pkg
`timescale 1ns / 1ps

module tccw_sequencer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tccw_pkg::seq_status_t st,
	output tccw_pkg::ucw_t        cw,
	output logic                  go,
	output logic                  emit
);

	tccw_pkg::step_t step_q;
	tccw_pkg::step_t step_d;
	tccw_pkg::step_t dispatch;
	logic            taken;
	logic            emit_req;

	assign cw = tccw_pkg::ucode(step_q);

	// branch condition and operation dispatch
	always_comb begin
		case (cw.cond)
			tccw_pkg::C_DISPATCH:   taken = st.accept;
			tccw_pkg::C_ALWAYS:     taken = 1'b1;
			tccw_pkg::C_SCROLL:     taken = st.scroll;
			tccw_pkg::C_COPY_LAST:  taken = st.copy_last;
			tccw_pkg::C_BLANK_LAST: taken = st.blank_last;
			default:                taken = 1'b0;
		endcase
		case (st.func)
			tccw_pkg::FN_PUT:   dispatch = tccw_pkg::ST_PUT;
			tccw_pkg::FN_CLEAR: dispatch = tccw_pkg::ST_CLEAR;
			tccw_pkg::FN_READ:  dispatch = tccw_pkg::ST_READ;
			default:            dispatch = tccw_pkg::ST_NOP;
		endcase
	end

	// result hand-off; a step that hands off a result holds while the output register is full and not drained
	always_comb begin
		case (cw.emit)
			tccw_pkg::EM_TAKEN:     emit_req = taken;
			tccw_pkg::EM_NOT_TAKEN: emit_req = !taken;
			tccw_pkg::EM_ALWAYS:    emit_req = 1'b1;
			default:                emit_req = 1'b0;
		endcase
		go   = !(emit_req && st.out_busy);
		emit = emit_req && go;
	end

	// next step
	always_comb begin
		if (!go) begin
			step_d = step_q;
		end else if (cw.cond == tccw_pkg::C_DISPATCH) begin
			step_d = taken ? dispatch : tccw_pkg::ST_FETCH;
		end else begin
			step_d = taken ? cw.next_t : cw.next_f;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= tccw_pkg::ST_FETCH;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

// ===== tb/tb_text_console_cell_writer_top.sv =====
// testbench for the text console cell writer: stream requests against a
// cycle-free mirror of the screen, cursor and color registers
// depends on tccw_pkg and text_console_cell_writer_top
`timescale 1ns / 1ps

module tb_text_console_cell_writer_top;

	localparam logic [tccw_pkg::FUNC_W-1:0] FN_UNUSED = 2'd3;
	localparam int IDX_MAX      = (1 << tccw_pkg::IDX_W) - 1;
	localparam int PHASES       = 5;
	localparam int PHASE_ITEMS  = 140;
	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 10000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [tccw_pkg::POS_W-1:0]  cursor;
		logic [tccw_pkg::CELL_W-1:0] cell_data;
		logic                        scrolled;
	} console_result_t;

	// mirror of the console: screen store, cursor, colors and the results owed
	class console_mirror;
		logic [tccw_pkg::CELL_W-1:0]  screen [tccw_pkg::CELLS];
		bit                           written [tccw_pkg::CELLS];
		int                           col = 0;
		int                           row = 0;
		logic [tccw_pkg::COLOR_W-1:0] fg = 4'd15;
		logic [tccw_pkg::COLOR_W-1:0] bg = 4'd0;
		console_result_t              awaited_results [$];
		int                           mismatches = 0;

		function void note_config(tccw_pkg::reg_idx_t r,
				logic [tccw_pkg::COLOR_W-1:0] v);
			if (r == tccw_pkg::REG_FG)
				fg = v;
			else
				bg = v;
		endfunction

		function logic [tccw_pkg::CELL_W-1:0] colored(logic [tccw_pkg::CHAR_W-1:0] ch);
			return {bg, fg, ch};
		endfunction

		function bit is_written(int i);
			return written[i];
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction

		// move every line up one and blank the bottom line
		function void scroll_up();
			int i;
			for (i = 0; i < (tccw_pkg::ROWS - 1) * tccw_pkg::COLS; i++) begin
				screen[i] = screen[i + tccw_pkg::COLS];
				written[i] = written[i + tccw_pkg::COLS];
			end
			for (i = (tccw_pkg::ROWS - 1) * tccw_pkg::COLS; i < tccw_pkg::CELLS; i++) begin
				screen[i] = colored(tccw_pkg::CH_SPACE);
				written[i] = 1'b1;
			end
		endfunction

		function void note_request(logic [tccw_pkg::FUNC_W-1:0] f,
				logic [tccw_pkg::CHAR_W-1:0] ch, logic [tccw_pkg::IDX_W-1:0] idx);
			console_result_t r;
			int i;
			r = '0;
			if (f == tccw_pkg::FN_PUT) begin
				if (ch == tccw_pkg::CH_BACKSPACE) begin
					if (col > 0)
						col--;
				end else if (ch == tccw_pkg::CH_TAB) begin
					col = (col + tccw_pkg::TAB_STOP) & ~(tccw_pkg::TAB_STOP - 1);
				end else if (ch == tccw_pkg::CH_RETURN) begin
					col = 0;
				end else if (ch == tccw_pkg::CH_NEWLINE) begin
					col = 0;
					row++;
				end else begin
					screen[row * tccw_pkg::COLS + col] = colored(ch);
					written[row * tccw_pkg::COLS + col] = 1'b1;
					col++;
				end
				// wrap, then scroll when the cursor ran off the bottom
				if (col >= tccw_pkg::COLS) begin
					col = 0;
					row++;
				end
				if (row >= tccw_pkg::ROWS) begin
					scroll_up();
					row = tccw_pkg::ROWS - 1;
					r.scrolled = 1'b1;
				end
			end else if (f == tccw_pkg::FN_CLEAR) begin
				for (i = 0; i < tccw_pkg::CELLS; i++) begin
					screen[i] = colored(tccw_pkg::CH_SPACE);
					written[i] = 1'b1;
				end
				col = 0;
				row = 0;
			end else if (f == tccw_pkg::FN_READ) begin
				if (idx < tccw_pkg::CELLS)
					r.cell_data = screen[idx];
			end
			r.cursor = tccw_pkg::POS_W'(row * tccw_pkg::COLS + col);
			awaited_results.push_back(r);
		endfunction

		function void check_result(logic [tccw_pkg::OUT_DATA_W-1:0] d);
			console_result_t got, want;
			got.cursor = d[tccw_pkg::POS_W-1:0];
			got.cell_data = d[tccw_pkg::POS_W +: tccw_pkg::CELL_W];
			got.scrolled = d[tccw_pkg::POS_W + tccw_pkg::CELL_W];
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: cursor %0d cell %h scroll %b",
						got.cursor, got.cell_data, got.scrolled);
				return;
			end
			want = awaited_results.pop_front();
			if (got.cursor != want.cursor || got.cell_data != want.cell_data ||
					got.scrolled != want.scrolled) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: cursor %0d/%0d cell %h/%h scroll %b/%b (exp/got)",
						want.cursor, got.cursor, want.cell_data, got.cell_data,
						want.scrolled, got.scrolled);
			end
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [tccw_pkg::IN_DATA_W-1:0]  s_tdata;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [tccw_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic                            cfg_index;
	logic [tccw_pkg::COLOR_W-1:0]    cfg_data;

	console_mirror mirror;
	int  burst_left = 0;
	bit  long_hold = 1'b0;
	int  idle_cycles = 0;

	text_console_cell_writer_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// offer one request, with a random gap at the start of most bursts
	task automatic send_request(logic [tccw_pkg::FUNC_W-1:0] f,
			logic [tccw_pkg::CHAR_W-1:0] ch, logic [tccw_pkg::IDX_W-1:0] idx);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			if ($urandom_range(0, 3) != 0)
				gap = $urandom_range(1, 12);
		end
		burst_left--;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, idx, ch, f};
		do @(posedge clk); while (!s_tready);
		mirror.note_request(f, ch, idx);
	endtask

	task automatic put_char(logic [tccw_pkg::CHAR_W-1:0] ch);
		send_request(tccw_pkg::FN_PUT, ch, tccw_pkg::IDX_W'($urandom));
	endtask

	// both color registers, back to back, only while the block is idle
	task automatic write_colors(logic [tccw_pkg::COLOR_W-1:0] fg_v,
			logic [tccw_pkg::COLOR_W-1:0] bg_v);
		cfg_valid <= 1'b1;
		cfg_index <= tccw_pkg::REG_FG;
		cfg_data <= fg_v;
		do @(posedge clk); while (!cfg_ready);
		mirror.note_config(tccw_pkg::REG_FG, fg_v);
		cfg_index <= tccw_pkg::REG_BG;
		cfg_data <= bg_v;
		do @(posedge clk); while (!cfg_ready);
		mirror.note_config(tccw_pkg::REG_BG, bg_v);
		cfg_valid <= 1'b0;
	endtask

	// read index: mostly a cell already written, sometimes past the end
	function automatic logic [tccw_pkg::IDX_W-1:0] pick_read_index();
		int i;
		int tries;
		if ($urandom_range(0, 6) == 0)
			return tccw_pkg::IDX_W'($urandom_range(tccw_pkg::CELLS, IDX_MAX));
		for (tries = 0; tries < 64; tries++) begin
			i = $urandom_range(0, tccw_pkg::CELLS - 1);
			if (mirror.is_written(i))
				return tccw_pkg::IDX_W'(i);
		end
		return tccw_pkg::IDX_W'($urandom_range(tccw_pkg::CELLS, IDX_MAX));
	endfunction

	task automatic wait_idle();
		while (mirror.pending() != 0) @(posedge clk);
	endtask

	// random runs of text, tabs, line breaks, backspaces, reads, clears and unused codes
	task automatic run_phase(int n_items);
		int sent;
		int kind;
		int len;
		int k;
		sent = 0;
		while (sent < n_items) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 100)
					: $urandom_range(1, 30);
				for (k = 0; k < len; k++)
					put_char(tccw_pkg::CHAR_W'($urandom_range(0, 255)));
			end else if (kind < 52) begin
				len = $urandom_range(1, 12);
				for (k = 0; k < len; k++)
					put_char(tccw_pkg::CH_TAB);
			end else if (kind < 62) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 30)
					: $urandom_range(1, 4);
				for (k = 0; k < len; k++)
					put_char(($urandom_range(0, 3) == 0) ? tccw_pkg::CH_RETURN
						: tccw_pkg::CH_NEWLINE);
			end else if (kind < 70) begin
				len = $urandom_range(1, 8);
				for (k = 0; k < len; k++)
					put_char(tccw_pkg::CH_BACKSPACE);
			end else if (kind < 86) begin
				len = $urandom_range(1, 4);
				for (k = 0; k < len; k++)
					send_request(tccw_pkg::FN_READ, tccw_pkg::CHAR_W'($urandom),
						pick_read_index());
			end else if (kind < 90) begin
				len = 1;
				send_request(tccw_pkg::FN_CLEAR, tccw_pkg::CHAR_W'($urandom),
					tccw_pkg::IDX_W'($urandom));
			end else if (kind < 95) begin
				len = 1;
				send_request(FN_UNUSED, tccw_pkg::CHAR_W'($urandom),
					tccw_pkg::IDX_W'($urandom));
			end else begin
				len = 1;
				case ($urandom_range(0, 3))
					0: put_char(tccw_pkg::CH_BACKSPACE);
					1: put_char(tccw_pkg::CH_TAB);
					2: put_char(tccw_pkg::CH_NEWLINE);
					default: put_char(tccw_pkg::CH_RETURN);
				endcase
			end
			sent += len;
		end
		s_tvalid <= 1'b0;
	endtask

	// output side: stall patterns of varying density, plus one long hold-off
	initial begin : sink
		int mode;
		int span;
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(1, 60);
				repeat (span) begin
					case (mode)
						0: m_tready <= 1'b1;
						1: m_tready <= 1'($urandom_range(0, 1));
						2: m_tready <= ($urandom_range(0, 7) != 0);
						default: m_tready <= ($urandom_range(0, 3) == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// result checking
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			mirror.check_result(m_tdata);
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb_text_console_cell_writer_top: done, errors");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [tccw_pkg::COLOR_W-1:0] fg_list [PHASES];
		logic [tccw_pkg::COLOR_W-1:0] bg_list [PHASES];
		int p;
		mirror = new;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= tccw_pkg::REG_FG;
		cfg_data <= '0;
		fg_list = '{4'd0, 4'd15, 4'd0, 4'd15, tccw_pkg::COLOR_W'($urandom)};
		bg_list = '{4'd15, 4'd15, 4'd0, 4'd0, tccw_pkg::COLOR_W'($urandom)};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: out of range reads, unused code, edits on the first line, clear
		send_request(tccw_pkg::FN_READ, 8'h00, tccw_pkg::IDX_W'(IDX_MAX));
		send_request(tccw_pkg::FN_READ, 8'hFF, tccw_pkg::IDX_W'(tccw_pkg::CELLS));
		send_request(FN_UNUSED, 8'hFF, tccw_pkg::IDX_W'(IDX_MAX));
		put_char(tccw_pkg::CH_BACKSPACE);
		put_char(8'h41);
		put_char(8'h00);
		put_char(8'hFF);
		send_request(tccw_pkg::FN_READ, 8'h00, 11'd0);
		send_request(tccw_pkg::FN_READ, 8'h00, 11'd1);
		send_request(tccw_pkg::FN_READ, 8'h00, 11'd2);
		put_char(tccw_pkg::CH_BACKSPACE);
		put_char(tccw_pkg::CH_TAB);
		put_char(8'h7E);
		send_request(tccw_pkg::FN_READ, 8'h00, 11'd8);
		put_char(tccw_pkg::CH_RETURN);
		put_char(tccw_pkg::CH_NEWLINE);
		send_request(tccw_pkg::FN_CLEAR, 8'hFF, tccw_pkg::IDX_W'(IDX_MAX));
		send_request(tccw_pkg::FN_READ, 8'h00, tccw_pkg::IDX_W'(tccw_pkg::CELLS - 1));
		send_request(tccw_pkg::FN_READ, 8'h00, 11'd0);
		put_char(tccw_pkg::CH_SPACE);
		s_tvalid <= 1'b0;

		// random phases, each under its own colors
		for (p = 0; p < PHASES; p++) begin
			wait_idle();
			write_colors(fg_list[p], bg_list[p]);
			if (p == 1)
				long_hold = 1'b1;
			run_phase(PHASE_ITEMS);
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mirror.mismatches == 0 && mirror.pending() == 0)
			$display("tb_text_console_cell_writer_top: done, clean");
		else
			$display("tb_text_console_cell_writer_top: done, errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/tccw_pkg.sv
src/tccw_screen_ram.sv
src/tccw_sequencer.sv
src/text_console_cell_writer_top.sv
tb/tb_text_console_cell_writer_top.sv
